[sv/jvr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvr_pkg: shared types and constants of the joystick view rotator
// State encoding, datapath widths, configuration register indexes and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package jvr_pkg;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_ROT_START,
        ST_CORDIC,
        ST_MUL,
        ST_OUT
    } t_state;

    // Field widths
    localparam int AXIS_W  = 8;
    localparam int SPEED_W = 14;
    localparam int DZ_W    = 7;
    localparam int VEC_W   = 16;

    // Angle magnitude in Q0.14 holds SPEED_W bits
    localparam int ANG_W   = SPEED_W;
    // CORDIC x, y and z in Q.30 with headroom
    localparam int CRD_W   = 33;
    // Rotation products and their sums
    localparam int PROD_W  = VEC_W + CRD_W;
    localparam int ACC_W   = PROD_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SPEED_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 2'd1;

    // Reset values
    localparam logic [SPEED_W-1:0]      SPEED_RST   = 14'd820;
    localparam logic [DZ_W-1:0]         DZ_RST      = 7'd10;
    localparam logic signed [VEC_W-1:0] HEAD_X_RST  = -16'sd16384;
    localparam logic signed [VEC_W-1:0] HEAD_Y_RST  = 16'sd0;
    localparam logic signed [VEC_W-1:0] PLANE_X_RST = 16'sd0;
    localparam logic signed [VEC_W-1:0] PLANE_Y_RST = 16'sd10813;

    // Asymptotic CORDIC gain, Q.30
    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 33'sd652032874;
    // Rounding half for the Q.30 product shift
    localparam logic signed [ACC_W-1:0] HALF_Q30 = 50'sd536870912;

    // atan(2^-i) in Q.30, rounded to nearest
    function automatic logic [CRD_W-1:0] atan_q30(input logic [4:0] idx);
        logic [CRD_W-1:0] v;
        case (idx)
            5'd0:    v = 33'd843314857;
            5'd1:    v = 33'd497837829;
            5'd2:    v = 33'd263043837;
            5'd3:    v = 33'd133525159;
            5'd4:    v = 33'd67021687;
            5'd5:    v = 33'd33543516;
            5'd6:    v = 33'd16775851;
            5'd7:    v = 33'd8388437;
            5'd8:    v = 33'd4194283;
            5'd9:    v = 33'd2097149;
            5'd10:   v = 33'd1048576;
            5'd11:   v = 33'd524288;
            5'd12:   v = 33'd262144;
            5'd13:   v = 33'd131072;
            5'd14:   v = 33'd65536;
            5'd15:   v = 33'd32768;
            5'd16:   v = 33'd16384;
            5'd17:   v = 33'd8192;
            5'd18:   v = 33'd4096;
            5'd19:   v = 33'd2048;
            5'd20:   v = 33'd1024;
            5'd21:   v = 33'd512;
            5'd22:   v = 33'd256;
            5'd23:   v = 33'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/jvr_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvr_cordic: iterative rotation-mode CORDIC
// One shift-add step per cycle starting from (K, 0); gives cos and sin of the
// start angle in Q.30. o_done pulses for one cycle after the last step, and
// the results hold until the next start.
// ----------------------------------------------------------------------------
module jvr_cordic #(
    parameter int STEPS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [jvr_pkg::CRD_W-1:0] i_angle,
    output logic                             o_done,
    output logic signed [jvr_pkg::CRD_W-1:0] o_cos,
    output logic signed [jvr_pkg::CRD_W-1:0] o_sin
);

    localparam int STEP_W = $clog2(STEPS);

    logic                             r_busy;
    logic                             r_done;
    logic [STEP_W-1:0]                r_step;
    logic signed [jvr_pkg::CRD_W-1:0] r_x;
    logic signed [jvr_pkg::CRD_W-1:0] r_y;
    logic signed [jvr_pkg::CRD_W-1:0] r_z;

    logic signed [jvr_pkg::CRD_W-1:0] w_dx;
    logic signed [jvr_pkg::CRD_W-1:0] w_dy;
    logic signed [jvr_pkg::CRD_W-1:0] w_atan;
    logic                             w_last;

    // shared shifter and table lookup for the current step
    assign w_dx   = r_y >>> r_step;
    assign w_dy   = r_x >>> r_step;
    assign w_atan = $signed(jvr_pkg::atan_q30(5'(r_step)));
    assign w_last = (r_step == STEP_W'(STEPS - 1));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // micro-rotation; z >= 0 turns positive
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= jvr_pkg::CORDIC_GAIN;
            r_y <= '0;
            r_z <= i_angle;
        end else if (r_busy) begin
            if (!r_z[jvr_pkg::CRD_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;

endmodule

[sv/joystick_view_rotator.sv]
`timescale 1ns / 1ps
// A sample inside the dead zone runs prep and then the output load; a
// rotation runs prep, scale, CORDIC start, the CORDIC steps and done, the
// multiplier products and the output load.
// A new sample is taken only after the last one is loaded into the output
// word, so a stalled output word holds the input off.
// Reset (i_rst_n low, synchronous) restores vectors and registers to defaults.
// ----------------------------------------------------------------------------
// joystick_view_rotator: rotates view direction and camera plane by a stick
// A reciprocal multiply scales the angle, a CORDIC gives cos and sin, and
// one multiplier applies the rotation to both vectors, all in fixed point.
// ----------------------------------------------------------------------------
module joystick_view_rotator #(
    parameter int CORDIC_STEPS = 16,
    parameter int FULL_SCALE   = 100
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream; tdata: [7:0] axis_percent
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,
    // output stream; tdata: [15:0] view_dir_x, [31:16] view_dir_y,
    // [47:32] view_plane_x, [63:48] view_plane_y
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [63:0]                        o_m_axis_tdata,
    // tuser: [0] did_rotate
    output logic                               o_m_axis_tuser,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jvr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jvr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DVD_W   = jvr_pkg::SPEED_W + jvr_pkg::AXIS_W;
    localparam int MCNT_W  = 4;
    localparam int MUL_OPS = 8;

    // floor(x / FULL_SCALE) as (x * ceil(2^(DVD_W+l) / FULL_SCALE)) >> (DVD_W+l),
    // l = clog2(FULL_SCALE); exact for every DVD_W-bit x
    localparam int     FS_L    = $clog2(FULL_SCALE);
    localparam int     RCP_SH  = DVD_W + FS_L;
    localparam int     RCP_W   = DVD_W + 2;
    localparam int     QPROD_W = DVD_W + RCP_W;
    localparam longint RCP_VAL = ((64'sd1 << RCP_SH) + longint'(FULL_SCALE) - 64'sd1)
                                 / longint'(FULL_SCALE);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

    // round Q.30 sum to Q2.14 and saturate
    function automatic logic signed [jvr_pkg::VEC_W-1:0] sat_round(
        input logic signed [jvr_pkg::ACC_W-1:0] v
    );
        logic signed [jvr_pkg::ACC_W-1:0] s;
        logic signed [jvr_pkg::VEC_W-1:0] r;
        s = (v + jvr_pkg::HALF_Q30) >>> 30;
        if (s > 50'sd32767) begin
            r = 16'sh7fff;
        end else if (s < -50'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = jvr_pkg::VEC_W'(s);
        end
        return r;
    endfunction

    jvr_pkg::t_state r_state;
    jvr_pkg::t_state n_state;

    // configuration
    logic [jvr_pkg::SPEED_W-1:0] r_speed;
    logic [jvr_pkg::DZ_W-1:0]    r_dead_zone;

    // vector state: 0 dir x, 1 dir y, 2 plane x, 3 plane y
    logic signed [jvr_pkg::VEC_W-1:0] r_vec [4];
    logic signed [jvr_pkg::VEC_W-1:0] r_new [4];

    // sample and angle scaling
    logic signed [jvr_pkg::AXIS_W-1:0] r_axis;
    logic                              r_rotate;
    logic [DVD_W-1:0]                  r_scaled;
    logic [jvr_pkg::ANG_W-1:0]         r_quot;

    // multiplier
    logic [MCNT_W-1:0]                 r_mul_cnt;
    logic signed [jvr_pkg::PROD_W-1:0] r_prod;
    logic signed [jvr_pkg::ACC_W-1:0]  r_acc;

    // output word
    logic                             r_m_tvalid;
    logic signed [jvr_pkg::VEC_W-1:0] r_out [4];
    logic                             r_out_rot;

    // control from the sequencer
    logic w_accept_in;
    logic w_cordic_start;
    logic w_load_out;
    logic w_mul_last;
    logic w_cordic_done;

    // datapath helpers
    logic [jvr_pkg::AXIS_W-1:0]        w_mag;
    logic [jvr_pkg::AXIS_W-1:0]        w_m;
    logic [DVD_W-1:0]                  w_scaled;
    logic [QPROD_W-1:0]                w_qprod;
    logic signed [jvr_pkg::CRD_W-1:0]  w_angle;
    logic signed [jvr_pkg::CRD_W-1:0]  w_cos;
    logic signed [jvr_pkg::CRD_W-1:0]  w_sin;
    logic [2:0]                        w_op;
    logic [2:0]                        w_op_prev;
    logic signed [jvr_pkg::VEC_W-1:0]  w_mul_a;
    logic signed [jvr_pkg::CRD_W-1:0]  w_mul_b;
    logic signed [jvr_pkg::ACC_W-1:0]  w_sum;

    // ------------------------------------------------------------------
    // magnitude, clamp and scaled dividend
    assign w_mag    = r_axis[jvr_pkg::AXIS_W-1] ? (~r_axis + 1'b1) : r_axis;
    assign w_m      = (32'(w_mag) > FULL_SCALE) ? jvr_pkg::AXIS_W'(FULL_SCALE) : w_mag;
    assign w_scaled = DVD_W'(r_speed) * DVD_W'(w_m);

    // divide by FULL_SCALE through the reciprocal
    assign w_qprod = QPROD_W'(r_scaled) * QPROD_W'(RCP);

    // angle in Q.30, clockwise for a positive axis
    always_comb begin
        w_angle = $signed({3'b000, r_quot, 16'h0000});
        if (!r_axis[jvr_pkg::AXIS_W-1]) begin
            w_angle = -w_angle;
        end
    end

    jvr_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_start),
        .i_angle (w_angle),
        .o_done  (w_cordic_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // multiplier operand select: per component one cos and one sin product
    assign w_op       = r_mul_cnt[2:0];
    assign w_op_prev  = 3'(r_mul_cnt - 1'b1);
    assign w_mul_last = (r_mul_cnt == MCNT_W'(MUL_OPS));
    assign w_mul_a    = r_vec[{w_op[2], w_op[0]}];
    assign w_mul_b    = (w_op[0] == w_op[1]) ? w_cos : w_sin;

    // x' = a*c - b*s, y' = a*s + b*c
    always_comb begin
        if (w_op_prev[1]) begin
            w_sum = r_acc + jvr_pkg::ACC_W'(r_prod);
        end else begin
            w_sum = r_acc - jvr_pkg::ACC_W'(r_prod);
        end
    end

    // ------------------------------------------------------------------
    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jvr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and controls
    always_comb begin
        n_state        = r_state;
        w_accept_in    = 1'b0;
        w_cordic_start = 1'b0;
        w_load_out     = 1'b0;
        case (r_state)
            jvr_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    w_accept_in = 1'b1;
                    n_state     = jvr_pkg::ST_PREP;
                end
            end
            jvr_pkg::ST_PREP: begin
                if (w_mag > jvr_pkg::AXIS_W'(r_dead_zone)) begin
                    n_state = jvr_pkg::ST_DIV;
                end else begin
                    n_state = jvr_pkg::ST_OUT;
                end
            end
            jvr_pkg::ST_DIV: begin
                n_state = jvr_pkg::ST_ROT_START;
            end
            jvr_pkg::ST_ROT_START: begin
                w_cordic_start = 1'b1;
                n_state        = jvr_pkg::ST_CORDIC;
            end
            jvr_pkg::ST_CORDIC: begin
                if (w_cordic_done) begin
                    n_state = jvr_pkg::ST_MUL;
                end
            end
            jvr_pkg::ST_MUL: begin
                if (w_mul_last) begin
                    n_state = jvr_pkg::ST_OUT;
                end
            end
            jvr_pkg::ST_OUT: begin
                if (!r_m_tvalid || i_m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = jvr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jvr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= jvr_pkg::SPEED_RST;
            r_dead_zone <= jvr_pkg::DZ_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jvr_pkg::CFG_ROTATION_SPEED: r_speed     <= i_cfg_data;
                jvr_pkg::CFG_DEAD_ZONE:      r_dead_zone <= i_cfg_data[jvr_pkg::DZ_W-1:0];
                default: ;
            endcase
        end
    end

    // vector state, committed with the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec[0] <= jvr_pkg::HEAD_X_RST;
            r_vec[1] <= jvr_pkg::HEAD_Y_RST;
            r_vec[2] <= jvr_pkg::PLANE_X_RST;
            r_vec[3] <= jvr_pkg::PLANE_Y_RST;
        end else if (w_load_out) begin
            r_vec <= r_new;
        end
    end

    // sample capture, angle scaling and multiply-accumulate
    always_ff @(posedge i_clk) begin
        if (w_accept_in) begin
            r_axis <= $signed(i_s_axis_tdata);
        end
        case (r_state)
            jvr_pkg::ST_PREP: begin
                r_rotate  <= (w_mag > jvr_pkg::AXIS_W'(r_dead_zone));
                r_scaled  <= w_scaled;
                r_mul_cnt <= '0;
                r_new     <= r_vec;
            end
            jvr_pkg::ST_DIV: begin
                r_quot    <= jvr_pkg::ANG_W'(w_qprod >> RCP_SH);
            end
            jvr_pkg::ST_MUL: begin
                r_prod    <= w_mul_a * w_mul_b;
                r_mul_cnt <= r_mul_cnt + 1'b1;
                if (r_mul_cnt != '0) begin
                    if (!w_op_prev[0]) begin
                        r_acc <= jvr_pkg::ACC_W'(r_prod);
                    end else begin
                        r_new[w_op_prev[2:1]] <= sat_round(w_sum);
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_load_out) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out     <= r_new;
            r_out_rot <= r_rotate;
        end
    end

    assign o_s_axis_tready = (r_state == jvr_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = {r_out[3], r_out[2], r_out[1], r_out[0]};
    assign o_m_axis_tuser  = r_out_rot;
    assign o_cfg_ready     = 1'b1;

endmodule

[sv/jvr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvr_checker: port-level checks for the joystick view rotator
// Watches the stream ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module jvr_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               o_s_axis_tready,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [63:0]                        o_m_axis_tdata,
    input  logic                               o_m_axis_tuser
);

    logic w_in_word;
    assign w_in_word = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled output word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    // a stalled output word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output payload changed while stalled");

    // one sample at a time: busy right after taking a word
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_word |=> !o_s_axis_tready)
        else $error("input still ready after accepting a word");

    // no new output word appears right after a word is taken
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_word |=> !$rose(o_m_axis_tvalid))
        else $error("output word appeared too early");

endmodule

bind joystick_view_rotator jvr_checker u_jvr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
